@@ rtl/rlfs_pkg.sv @@
// shared constants and types for the loss fraction statistics block
package rlfs_pkg;

    localparam int CNT_W     = 32;
    localparam int SEQ_W     = 16;
    localparam int GAP_W     = 16;
    localparam int ACT_W     = 2;
    localparam int FRAC_W    = 8;
    localparam int DIV_STEPS = FRAC_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [GAP_W-1:0]  GAP_LIMIT_RESET = GAP_W'(100);
    localparam logic [FRAC_W-1:0] FRAC_MAX        = {FRAC_W{1'b1}};

    // action codes carried in tuser
    localparam logic [ACT_W-1:0] ACT_FRAME  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REPORT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic frame_en;
        logic report_en;
        logic clear_en;
        logic div_step;
        logic out_load;
    } cmd_t;

endpackage

@@ rtl/rlfs_datapath.sv @@
// counters, snapshots, gap check, serial fraction divider and output register
module rlfs_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wen,
    input  logic [rlfs_pkg::GAP_W-1:0]   cfg_wdata,
    input  logic [rlfs_pkg::SEQ_W-1:0]   seq_number,
    input  rlfs_pkg::cmd_t               cmd,
    output logic [rlfs_pkg::FRAC_W-1:0]  lost_fraction
);

    localparam int CW = rlfs_pkg::CNT_W;

    logic [rlfs_pkg::GAP_W-1:0]  gap_limit_reg;
    logic [CW-1:0]               exp_total_reg, exp_total_next;
    logic [CW-1:0]               lost_total_reg, lost_total_next;
    logic [CW-1:0]               exp_snap_reg;
    logic [CW-1:0]               lost_snap_reg;
    logic [rlfs_pkg::SEQ_W-1:0]  prev_seq_reg;

    logic [CW-1:0]               den_reg;
    logic [CW-1:0]               rem_reg, rem_next;
    logic [rlfs_pkg::FRAC_W-1:0] quo_reg, quo_next;
    logic                        den_zero_reg;
    logic                        sat_reg;
    logic [rlfs_pkg::FRAC_W-1:0] frac_reg;

    logic [rlfs_pkg::SEQ_W-1:0]  gap;
    logic                        gap_ok;
    logic [CW-1:0]               exp_inc;
    logic [CW-1:0]               d_exp;
    logic [CW-1:0]               d_lost;
    logic [CW:0]                 rem_shift;
    logic                        rem_ge;

    // gap check for a frame
    assign gap    = seq_number - prev_seq_reg - rlfs_pkg::SEQ_W'(1);
    assign gap_ok = (prev_seq_reg != '0) && (gap != '0) && (gap < gap_limit_reg);
    assign exp_inc = gap_ok ? (CW'(gap) + CW'(1)) : CW'(1);
    assign exp_total_next  = exp_total_reg + exp_inc;
    assign lost_total_next = gap_ok ? (lost_total_reg + CW'(gap)) : lost_total_reg;

    // differences since last report
    assign d_exp  = exp_total_reg - exp_snap_reg;
    assign d_lost = lost_total_reg - lost_snap_reg;

    // one restoring division step
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_ge    = rem_shift >= {1'b0, den_reg};
    assign rem_next  = rem_ge ? CW'(rem_shift - {1'b0, den_reg}) : CW'(rem_shift);
    assign quo_next  = {quo_reg[rlfs_pkg::FRAC_W-2:0], rem_ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_limit_reg  <= rlfs_pkg::GAP_LIMIT_RESET;
            exp_total_reg  <= '0;
            lost_total_reg <= '0;
            exp_snap_reg   <= '0;
            lost_snap_reg  <= '0;
            prev_seq_reg   <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                gap_limit_reg <= cfg_wdata;
            end
            if (cmd.frame_en)
            begin
                exp_total_reg  <= exp_total_next;
                lost_total_reg <= lost_total_next;
                prev_seq_reg   <= seq_number;
            end
            else if (cmd.report_en)
            begin
                exp_snap_reg  <= exp_total_reg;
                lost_snap_reg <= lost_total_reg;
            end
            else if (cmd.clear_en)
            begin
                exp_total_reg  <= '0;
                lost_total_reg <= '0;
                exp_snap_reg   <= '0;
                lost_snap_reg  <= '0;
                prev_seq_reg   <= '0;
            end
        end
    end

    // divider and output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.report_en)
        begin
            den_reg      <= d_exp;
            rem_reg      <= d_lost;
            quo_reg      <= '0;
            den_zero_reg <= (d_exp == '0);
            sat_reg      <= (d_lost >= d_exp);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.out_load)
        begin
            frac_reg <= den_zero_reg ? '0 : (sat_reg ? rlfs_pkg::FRAC_MAX : quo_reg);
        end
    end

    assign lost_fraction = frac_reg;

endmodule

@@ rtl/rlfs_ctrl.sv @@
// handshake controller and sequencer for the fraction divider
module rlfs_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [rlfs_pkg::ACT_W-1:0]  action,
    output logic                        in_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output rlfs_pkg::cmd_t              cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                      state_reg, state_next;
    logic [rlfs_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        in_fire;
    logic                        out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.frame_en  = (action == rlfs_pkg::ACT_FRAME);
                    cmd.report_en = (action == rlfs_pkg::ACT_REPORT);
                    cmd.clear_en  = (action == rlfs_pkg::ACT_CLEAR);
                    if (action == rlfs_pkg::ACT_REPORT)
                    begin
                        state_next = ST_DIV;
                        step_next  = '0;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + rlfs_pkg::STEP_W'(1);
                if (step_reg == rlfs_pkg::STEP_W'(rlfs_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                    step_next  = '0;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // step counter only runs during the division
    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_DIV) |-> (step_reg == '0))
        else $error("step counter nonzero outside division");

    a_report_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.report_en |=> (state_reg == ST_DIV))
        else $error("report did not start division");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not presented after load");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("output register overwritten while held");

endmodule

@@ rtl/rtp_loss_fraction_stats_top.sv @@
// top level of the receive-side loss fraction statistics block
// Tracks frame loss on a received media stream from 16-bit sequence numbers.
// Each input item carries an action in s_axis_tuser: frame (0), report (1) or
// clear (2); action 3 is taken and ignored. A frame adds one to the expected
// count, plus the forward gap to both expected and lost counts when a nonzero
// previous sequence number exists and the gap lies strictly between 0 and
// gap_limit. A report returns one item with floor(lost*256/expected) over the
// counts since the previous report (0 if no frames, 255 on saturation) and moves
// the snapshot. Clear zeroes the counters but keeps gap_limit.
// Timing: frame, clear and ignored items can be taken back to back. A report
// latches the differences, runs the bit-serial restoring divider (one quotient
// bit per cycle) and loads the output register; it stretches further while a
// previous result is still held on the master side. No input is taken during
// a report; frames keep flowing while a loaded result waits. gap_limit must be
// written through cfg_wen/cfg_wdata only while the block is idle (not enforced).
module rtp_loss_fraction_stats_top (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: gap_limit
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] seq_number
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [7:0] lost_fraction
);

    rlfs_pkg::cmd_t cmd;

    // sequencer: owns the handshakes and the division step count
    rlfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .action    (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    // datapath: counters, snapshots, divider, result register
    rlfs_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .seq_number    (s_axis_tdata),
        .cmd           (cmd),
        .lost_fraction (m_axis_tdata)
    );

endmodule

@@ test/rtp_loss_fraction_stats_checker.sv @@
// checker for the loss fraction block: tracks the counters and compares each result item
module rtp_loss_fraction_stats_checker
    import rlfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wen,
    input  logic [GAP_W-1:0]  cfg_wdata,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [SEQ_W-1:0]  s_axis_tdata,
    input  logic [ACT_W-1:0]  s_axis_tuser,
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [FRAC_W-1:0] m_axis_tdata,
    output int                fail_count,
    output int                pending
);

    timeunit 1ns;
    timeprecision 1ps;

    logic [GAP_W-1:0]  gap_lim;
    logic [CNT_W-1:0]  rx_expected;
    logic [CNT_W-1:0]  rx_lost;
    logic [CNT_W-1:0]  mark_expected;
    logic [CNT_W-1:0]  mark_lost;
    logic [SEQ_W-1:0]  last_seq;
    logic [FRAC_W-1:0] fraction_q[$];
    int                fails;

    // lost frames per 256 expected, saturating when the lost count catches up
    function automatic logic [FRAC_W-1:0] loss_fraction(logic [CNT_W-1:0] dl,
                                                         logic [CNT_W-1:0] de);
        logic [CNT_W+FRAC_W-1:0] num;
        if (de == '0)
            return '0;
        if (dl >= de)
            return FRAC_MAX;
        num = {dl, {FRAC_W{1'b0}}};
        return FRAC_W'(num / de);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        logic [FRAC_W-1:0] want;
        logic [SEQ_W-1:0]  gap;
        if (!rst_n)
        begin
            gap_lim       = GAP_LIMIT_RESET;
            rx_expected   = '0;
            rx_lost       = '0;
            mark_expected = '0;
            mark_lost     = '0;
            last_seq      = '0;
            fraction_q.delete();
            fails         = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (fraction_q.size() == 0)
                begin
                    $error("lost_fraction: expected none, actual %0d", m_axis_tdata);
                    fails++;
                end
                else
                begin
                    want = fraction_q.pop_front();
                    if (m_axis_tdata !== want)
                    begin
                        $error("lost_fraction: expected %0d, actual %0d", want, m_axis_tdata);
                        fails++;
                    end
                end
            end

            if (cfg_wen)
                gap_lim = cfg_wdata;

            if (s_axis_tvalid && s_axis_tready)
            begin
                case (s_axis_tuser)
                    ACT_FRAME:
                    begin
                        rx_expected = rx_expected + 1'b1;
                        // a stored zero means no previous frame
                        if (last_seq != '0)
                        begin
                            gap = s_axis_tdata - last_seq - 1'b1;
                            if (gap != '0 && gap < gap_lim)
                            begin
                                rx_expected = rx_expected + CNT_W'(gap);
                                rx_lost     = rx_lost + CNT_W'(gap);
                            end
                        end
                        last_seq = s_axis_tdata;
                    end
                    ACT_REPORT:
                    begin
                        fraction_q.insert(fraction_q.size(),
                                          loss_fraction(rx_lost - mark_lost,
                                                        rx_expected - mark_expected));
                        mark_expected = rx_expected;
                        mark_lost     = rx_lost;
                    end
                    ACT_CLEAR:
                    begin
                        rx_expected   = '0;
                        rx_lost       = '0;
                        mark_expected = '0;
                        mark_lost     = '0;
                        last_seq      = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            fail_count <= fails;
            pending    <= fraction_q.size();
        end
    end

endmodule

@@ test/tb.sv @@
// testbench top for the loss fraction block: stimulus, receiver pacing and verdict
module tb;

    import rlfs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // action 3 is taken by the block and ignored
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    // leave a margin after a report before touching the register
    localparam int DRAIN_CYCLES = 16;
    // long receiver hold-off so that held results back up into the input
    localparam int HOLD_LEN     = 400;
    localparam int PHASE_ITEMS  = 235;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              cfg_wen       = 1'b0;
    logic [GAP_W-1:0]  cfg_wdata     = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [SEQ_W-1:0]  s_axis_tdata  = '0;   // [15:0] seq_number
    logic [ACT_W-1:0]  s_axis_tuser  = '0;   // [1:0] action
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [FRAC_W-1:0] m_axis_tdata;         // [7:0] lost_fraction

    int fail_count;
    int pending;

    // pacing knobs: percent of cycles the sender idles / the receiver stalls
    int send_idle_pct = 0;
    int stall_pct     = 0;
    logic hold_req    = 1'b0;
    int hold_count    = 0;

    // stimulus-side view of the sequence and the register, only to shape items
    logic [SEQ_W-1:0] tx_seq  = '0;
    logic [GAP_W-1:0] cur_gap = GAP_LIMIT_RESET;

    rtp_loss_fraction_stats_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rtp_loss_fraction_stats_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, plus one long hold-off counted here once requested
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_req && hold_count < HOLD_LEN)
        begin
            m_axis_tready <= 1'b0;
            hold_count    <= hold_count + 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // offer one item, with random idle cycles ahead of it, and wait for its handshake;
    // values sampled right after the edge are the ones the edge saw
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [SEQ_W-1:0] seq);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= seq;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // stop offering, let every expected result drain, then give the block time to settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write, only called while idle
    task automatic write_gap_limit(input logic [GAP_W-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        cur_gap    = value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    // mostly orderly frame runs with small gaps around the limit, then noise,
    // reports, clears and ignored items
    task automatic send_random();
        int pick;
        int gap_pick;
        logic [SEQ_W-1:0] step;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            gap_pick = $urandom_range(9);
            if (gap_pick < 6)
                step = SEQ_W'(1);
            else if (gap_pick < 9)
                step = SEQ_W'(1 + $urandom_range(int'(cur_gap) + 1));
            else
                step = SEQ_W'($urandom);
            tx_seq = tx_seq + step;
            send_item(ACT_FRAME, tx_seq);
        end
        else if (pick < 80)
        begin
            tx_seq = SEQ_W'($urandom);
            send_item(ACT_FRAME, tx_seq);
        end
        else if (pick < 90)
            send_item(ACT_REPORT, SEQ_W'($urandom));
        else if (pick < 94)
            send_item(ACT_CLEAR, SEQ_W'($urandom));
        else
            send_item(ACT_UNUSED, SEQ_W'($urandom));
    endtask

    initial
    begin : stimulus
        int guard;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part, reset gap limit of 100 ---
        // report before any frame gives zero
        send_item(ACT_REPORT, 16'h0000);
        // zero is stored, so the frame after it counts no gap
        send_item(ACT_FRAME, 16'd0);
        send_item(ACT_FRAME, 16'd5);
        send_item(ACT_FRAME, 16'd6);
        send_item(ACT_FRAME, 16'd9);       // two lost
        send_item(ACT_FRAME, 16'hffff);    // jump past the limit, resync
        send_item(ACT_FRAME, 16'd1);       // wrap through zero, one lost
        send_item(ACT_FRAME, 16'd100);     // 98 lost
        send_item(ACT_FRAME, 16'd200);     // 99 lost, just under the limit
        send_item(ACT_FRAME, 16'd301);     // exactly at the limit, ignored
        send_item(ACT_UNUSED, 16'hffff);   // ignored action
        send_item(ACT_REPORT, 16'hffff);
        send_item(ACT_REPORT, 16'h0000);   // nothing since the last report
        send_item(ACT_FRAME, 16'd300);     // backward step, huge forward gap
        send_item(ACT_FRAME, 16'd305);
        send_item(ACT_CLEAR, 16'h0000);
        send_item(ACT_REPORT, 16'h0000);   // cleared counters
        send_item(ACT_FRAME, 16'd10);
        send_item(ACT_FRAME, 16'd20);
        send_item(ACT_REPORT, 16'h0000);

        // limit of zero never counts a gap
        wait_idle();
        write_gap_limit(16'd0);
        send_item(ACT_FRAME, 16'd1);
        send_item(ACT_FRAME, 16'd3);
        send_item(ACT_FRAME, 16'd40);
        send_item(ACT_REPORT, 16'h0000);

        // widest limit: nearly every forward gap counts
        wait_idle();
        write_gap_limit(16'hffff);
        send_item(ACT_FRAME, 16'd1);
        send_item(ACT_FRAME, 16'hffff);
        send_item(ACT_REPORT, 16'h0000);

        // --- random phases, each with its own limit and pacing ---
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_idle();
            case (ph)
                0:
                begin
                    write_gap_limit(GAP_W'($urandom_range(300, 2)));
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                end
                1:
                begin
                    write_gap_limit(16'd1);
                    send_idle_pct = 75;
                    stall_pct    <= 0;
                end
                2:
                begin
                    write_gap_limit(16'hffff);
                    send_idle_pct = 0;
                    stall_pct    <= 75;
                end
                default:
                begin
                    write_gap_limit(GAP_W'($urandom_range(65535, 1)));
                    send_idle_pct = 23;
                    stall_pct    <= 23;
                end
            endcase
            tx_seq = SEQ_W'($urandom);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // long hold-off while items keep coming at full rate
                if (ph == 0 && i == 60)
                    hold_req <= 1'b1;
                send_random();
            end
        end

        // --- drain and verdict ---
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        guard = 0;
        while (pending != 0 && guard < 100000)
        begin
            guard++;
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending != 0)
            $error("lost_fraction: %0d expected items never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
rtl/rlfs_pkg.sv
rtl/rlfs_datapath.sv
rtl/rlfs_ctrl.sv
rtl/rtp_loss_fraction_stats_top.sv
test/rtp_loss_fraction_stats_checker.sv
test/tb.sv
